// ----- rtl/dq_pkg.sv -----
// Shared types and codes for the double-ended queue block.
package dq_pkg;

  localparam int DEFAULT_CAPACITY = 16;

  localparam int FUNC_W = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;

  // Operation codes carried in the func field of a request.
  localparam logic [FUNC_W-1:0] F_PUSH_BACK  = 3'd0;
  localparam logic [FUNC_W-1:0] F_PUSH_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] F_POP_BACK   = 3'd2;
  localparam logic [FUNC_W-1:0] F_POP_FRONT  = 3'd3;
  localparam logic [FUNC_W-1:0] F_LIST       = 3'd4;

  // Status codes returned with every result.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } rsp_t;

endpackage

// ----- rtl/double_ended_queue_top.sv -----
// Bounded double-ended queue of signed 32-bit elements held in a circular store.
//
// Each request transfer carries one operation: push at the back, push at the
// front, pop from the back, pop from the front, or list the whole contents.
// Every push and pop yields exactly one response transfer: a pop returns the
// removed element, a push into a full queue is refused with status full, and
// a pop from an empty queue answers with status empty. A list yields one
// response per element, from front to back, with its position and with last
// set on the final one; listing an empty queue yields a single empty response.
// Undefined operation codes leave the queue alone and return one all-zero
// response with last set. The block works on one request at a time and holds
// req_stall high until the final response of that request has been taken.
// A push, an undefined operation, or a pop or list of an empty queue passes
// through S_STEP and then S_OUT; a pop of a held element and each element of
// a non-empty list also pass through S_LOAD between those two states. This
// sequence comes from the single store port, whose read data is registered,
// and from the one slot adder that every address and pointer update passes
// through in turn under a small sequencer.
module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Slot index width and element count width (the count must reach CAPACITY).
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [CNT_W:0] CAP_WIDE = (CNT_W + 1)'(CAPACITY);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] S_STEP = 2'd1;  // address the store, write or read it
  localparam logic [1:0] S_LOAD = 2'd2;  // capture read data into the response
  localparam logic [1:0] S_OUT  = 2'd3;  // hold the response until it is taken

  logic [1:0]               state;
  logic [SLOT_W-1:0]        front;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         idx;
  logic [FUNC_W-1:0]        op_func;
  logic signed [DATA_W-1:0] op_value;
  rsp_t                     rsp_reg;

  // The element store: one write and one read per cycle, read data registered.
  logic signed [DATA_W-1:0] store [CAPACITY];
  logic signed [DATA_W-1:0] rd_data;
  logic                     store_we;

  // The shared slot adder: front plus an offset, wrapped around the store.
  logic [CNT_W-1:0]  offset;
  logic [CNT_W:0]    slot_sum;
  logic [CNT_W:0]    slot_wrap;
  logic [SLOT_W-1:0] slot;

  logic full;
  logic empty;
  logic list_done;

  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign list_done = ((idx + CNT_W'(1)) == count);

  always_comb begin
    offset = '0;
    if (state == S_LOAD) begin
      // Only a pop from the front uses the adder here, to step the front on.
      offset = CNT_W'(1);
    end else begin
      case (op_func)
        F_PUSH_BACK:  offset = count;
        F_PUSH_FRONT: offset = CNT_W'(CAPACITY - 1);
        F_POP_BACK:   offset = count - CNT_W'(1);
        F_POP_FRONT:  offset = '0;
        F_LIST:       offset = idx;
        default:      offset = '0;
      endcase
    end
    slot_sum  = (CNT_W + 1)'(front) + (CNT_W + 1)'(offset);
    slot_wrap = (slot_sum >= CAP_WIDE) ? (slot_sum - CAP_WIDE) : slot_sum;
    slot      = slot_wrap[SLOT_W-1:0];
  end

  assign store_we = (state == S_STEP) && !full &&
                    ((op_func == F_PUSH_BACK) || (op_func == F_PUSH_FRONT));

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[slot] <= op_value;
    end
    rd_data <= store[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_func  <= req.func;
            op_value <= req.value;
            idx      <= '0;
            state    <= S_STEP;
          end
        end
        S_STEP: begin
          rsp_reg.data     <= '0;
          rsp_reg.position <= '0;
          rsp_reg.last     <= 1'b1;
          case (op_func) inside
            F_PUSH_BACK, F_PUSH_FRONT: begin
              state <= S_OUT;
              if (full) begin
                rsp_reg.status <= ST_FULL;
              end else begin
                rsp_reg.status <= ST_OK;
                count          <= count + CNT_W'(1);
                if (op_func == F_PUSH_FRONT) begin
                  front <= slot;
                end
              end
            end
            F_POP_BACK, F_POP_FRONT, F_LIST: begin
              if (empty) begin
                rsp_reg.status <= ST_EMPTY;
                state          <= S_OUT;
              end else begin
                // The read of the addressed slot lands in rd_data next cycle.
                state <= S_LOAD;
                if (op_func == F_POP_BACK) begin
                  count <= count - CNT_W'(1);
                end
              end
            end
            default: begin
              rsp_reg.status <= ST_OK;
              state          <= S_OUT;
            end
          endcase
        end
        S_LOAD: begin
          rsp_reg.data     <= rd_data;
          rsp_reg.position <= (op_func == F_LIST) ? POS_W'(idx) : '0;
          rsp_reg.status   <= ST_OK;
          rsp_reg.last     <= (op_func == F_LIST) ? list_done : 1'b1;
          if (op_func == F_POP_FRONT) begin
            front <= slot;
            count <= count - CNT_W'(1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_stall) begin
            if (!rsp_reg.last) begin
              idx   <= idx + CNT_W'(1);
              state <= S_STEP;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign rsp       = rsp_reg;

  // The element count never passes the capacity of the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count exceeds capacity");

  // Each request changes the element count by at most one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !rst |=> ((count == $past(count)) || (count == $past(count) + CNT_W'(1)) ||
              (count == $past(count) - CNT_W'(1))))
    else $error("element count jumped by more than one");

  // After the final response is taken the block takes requests again.
  a_release: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && rsp.last) |=> !req_stall)
    else $error("block stayed busy after the final response");

  // Only a push can be refused as full.
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == ST_FULL)) |->
      ((op_func == F_PUSH_BACK) || (op_func == F_PUSH_FRONT)))
    else $error("full status on an operation other than a push");

endmodule
